// ----- rtl/rmq_pkg.sv -----
// ---------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Case codes, control and lane flag structs used by the cells and the top.
// ---------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

   // default fractional bits of the Q format
   localparam int FRAC_BITS_DEF = 14;

   // width of a signed off-diagonal numerator
   localparam int NW = 17;

   // quotient bits produced by the divider chain
   localparam int QBITS = 17;

   // case codes
   localparam logic [2:0] KIND_IDENT = 3'd0;
   localparam logic [2:0] KIND_TRACE = 3'd1;
   localparam logic [2:0] KIND_XX    = 3'd2;
   localparam logic [2:0] KIND_YY    = 3'd3;
   localparam logic [2:0] KIND_ZZ    = 3'd4;

   // per-request control carried down the chain
   typedef struct packed {
      logic       valid;
      logic       ident;
      logic [2:0] kind;
   } rmq_ctl_type;

   // per-lane numerator flags
   typedef struct packed {
      logic neg;
      logic zero;
      logic sat;
   } rmq_lane_type;

endpackage

`default_nettype wire

// ----- rtl/rmq_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// rmq_sqrt_cell: one digit of the integer square root
// Consumes two radicand bits, produces one root bit, passes numerators on.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_cell #(
   parameter int VW2 = 34,
   parameter int RB  = 17
) (
   input  wire                             clock,
   input  wire                             reset,
   input  rmq_pkg::rmq_ctl_type            ctl_i,
   input  wire  [VW2-1:0]                  v_i,
   input  wire  [RB+2:0]                   rem_i,
   input  wire  [RB-1:0]                   root_i,
   input  wire  signed [rmq_pkg::NW-1:0]   num_i [3],
   output rmq_pkg::rmq_ctl_type            ctl_o,
   output logic [VW2-1:0]                  v_o,
   output logic [RB+2:0]                   rem_o,
   output logic [RB-1:0]                   root_o,
   output logic signed [rmq_pkg::NW-1:0]   num_o [3]
);
   import rmq_pkg::*;

   rmq_ctl_type          ctl_ff;
   logic [VW2-1:0]       v_ff, v_in;
   logic [RB+2:0]        rem_ff, rem_in;
   logic [RB-1:0]        root_ff, root_in;
   logic signed [NW-1:0] num_ff [3];
   logic [RB+2:0]        shifted;
   logic [RB+2:0]        trial;

   // restoring root step
   always_comb begin
      shifted = {rem_i[RB:0], v_i[VW2-1 -: 2]};
      trial   = {1'b0, root_i, 2'b01};
      v_in    = v_i << 2;
      if (shifted >= trial) begin
         rem_in  = shifted - trial;
         root_in = {root_i[RB-2:0], 1'b1};
      end else begin
         rem_in  = shifted;
         root_in = {root_i[RB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_i.valid;
      end
      ctl_ff.ident <= ctl_i.ident;
      ctl_ff.kind  <= ctl_i.kind;
      v_ff         <= v_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      num_ff       <= num_i;
   end

   assign ctl_o  = ctl_ff;
   assign v_o    = v_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign num_o  = num_ff;

endmodule

`default_nettype wire

// ----- rtl/rmq_div_cell.sv -----
// ---------------------------------------------------------------------------
// rmq_div_cell: one quotient bit for three lanes
// Restoring division step against 2*r shifted to bit position K.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_div_cell #(
   parameter int XW = 50,
   parameter int RB = 17,
   parameter int K  = 0
) (
   input  wire                               clock,
   input  wire                               reset,
   input  rmq_pkg::rmq_ctl_type              ctl_i,
   input  wire  [RB-1:0]                     root_i,
   input  rmq_pkg::rmq_lane_type             lane_i [3],
   input  wire  [XW-1:0]                     rem_i [3],
   input  wire  [rmq_pkg::QBITS-1:0]         q_i [3],
   output rmq_pkg::rmq_ctl_type              ctl_o,
   output logic [RB-1:0]                     root_o,
   output rmq_pkg::rmq_lane_type             lane_o [3],
   output logic [XW-1:0]                     rem_o [3],
   output logic [rmq_pkg::QBITS-1:0]         q_o [3]
);
   import rmq_pkg::*;

   rmq_ctl_type       ctl_ff;
   logic [RB-1:0]     root_ff;
   rmq_lane_type      lane_ff [3];
   logic [XW-1:0]     rem_ff [3], rem_in [3];
   logic [QBITS-1:0]  q_ff [3], q_in [3];
   logic [XW-1:0]     dsh;

   // trial subtract per lane
   always_comb begin
      dsh = XW'(root_i) << (K + 1);
      for (int l = 0; l < 3; l++) begin
         q_in[l] = q_i[l];
         if (rem_i[l] >= dsh) begin
            rem_in[l]  = rem_i[l] - dsh;
            q_in[l][K] = 1'b1;
         end else begin
            rem_in[l]  = rem_i[l];
            q_in[l][K] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_i.valid;
      end
      ctl_ff.ident <= ctl_i.ident;
      ctl_ff.kind  <= ctl_i.kind;
      root_ff      <= root_i;
      lane_ff      <= lane_i;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
   end

   assign ctl_o  = ctl_ff;
   assign root_o = root_ff;
   assign lane_o = lane_ff;
   assign rem_o  = rem_ff;
   assign q_o    = q_ff;

endmodule

`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Shepperd pivot selection, digit-serial root and divider cell chains.
// ---------------------------------------------------------------------------
// Usage:
//   A request is the nine matrix elements on req_m00..req_m22, taken on a
//   clock edge with start high and busy low. busy is high only in reset, so
//   a new request may be issued every cycle.
//   Each result appears on rsp_quat_w/x/y/z and rsp_case_taken for exactly
//   one cycle with rsp_valid high; the receiver cannot stall and results
//   come out in request order.
//   The chain is one input stage, RB square-root cells, where
//   RB = (max(FRAC_BITS,17) + 2 + FRAC_BITS + 1)/2 (one root bit each),
//   a divider setup stage, 17 divider cells (one quotient bit each for
//   all three numerators) and an output register.
//   Throughput is one request per cycle.
//   A synchronous reset empties the chain; requests in flight are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  signed [15:0] req_m00,
   input  wire  signed [15:0] req_m01,
   input  wire  signed [15:0] req_m02,
   input  wire  signed [15:0] req_m10,
   input  wire  signed [15:0] req_m11,
   input  wire  signed [15:0] req_m12,
   input  wire  signed [15:0] req_m20,
   input  wire  signed [15:0] req_m21,
   input  wire  signed [15:0] req_m22,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic [2:0]         rsp_case_taken
);
   import rmq_pkg::*;

   localparam int AGW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int RB  = (AGW + FRAC_BITS + 1) / 2;
   localparam int VW2 = 2 * RB;
   localparam int XW  = RB + FRAC_BITS + NW + 2;
   localparam logic signed [AGW-1:0] ONE_W = {{(AGW-1){1'b0}}, 1'b1} << FRAC_BITS;

   // ---------------- input stage ----------------
   logic signed [AGW-1:0] e00, e11, e22, trace, arg;
   logic                  accept;
   logic [2:0]            kind;
   logic signed [NW-1:0]  num_c [3];
   logic [VW2-1:0]        v_c;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      e00   = AGW'(req_m00);
      e11   = AGW'(req_m11);
      e22   = AGW'(req_m22);
      trace = e00 + e11 + e22;
      if (trace >= 0) begin
         kind     = KIND_TRACE;
         arg      = trace + ONE_W;
         num_c[0] = NW'(req_m21) - NW'(req_m12);
         num_c[1] = NW'(req_m02) - NW'(req_m20);
         num_c[2] = NW'(req_m10) - NW'(req_m01);
      end else if (req_m00 > req_m11 && req_m00 > req_m22) begin
         kind     = KIND_XX;
         arg      = ONE_W + e00 - e11 - e22;
         num_c[0] = NW'(req_m21) - NW'(req_m12);
         num_c[1] = NW'(req_m01) + NW'(req_m10);
         num_c[2] = NW'(req_m20) + NW'(req_m02);
      end else if (req_m11 > req_m22) begin
         kind     = KIND_YY;
         arg      = ONE_W + e11 - e22 - e00;
         num_c[0] = NW'(req_m02) - NW'(req_m20);
         num_c[1] = NW'(req_m01) + NW'(req_m10);
         num_c[2] = NW'(req_m12) + NW'(req_m21);
      end else begin
         kind     = KIND_ZZ;
         arg      = ONE_W + e22 - e00 - e11;
         num_c[0] = NW'(req_m10) - NW'(req_m01);
         num_c[1] = NW'(req_m20) + NW'(req_m02);
         num_c[2] = NW'(req_m12) + NW'(req_m21);
      end
      // clamp negative root argument, then scale by 2^FRAC_BITS
      if (arg[AGW-1]) begin
         v_c = '0;
      end else begin
         v_c = VW2'($unsigned(arg)) << FRAC_BITS;
      end
   end

   rmq_ctl_type          sq_ctl  [RB+1];
   logic [VW2-1:0]       sq_v    [RB+1];
   logic [RB+2:0]        sq_rem  [RB+1];
   logic [RB-1:0]        sq_root [RB+1];
   logic signed [NW-1:0] sq_num  [RB+1][3];

   rmq_ctl_type          in_ctl_ff;
   logic [VW2-1:0]       in_v_ff;
   logic signed [NW-1:0] in_num_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff.valid <= 1'b0;
      end else begin
         in_ctl_ff.valid <= accept;
      end
      in_ctl_ff.ident <= (e00 == ONE_W) && (e11 == ONE_W) && (e22 == ONE_W);
      in_ctl_ff.kind  <= kind;
      in_v_ff         <= v_c;
      in_num_ff       <= num_c;
   end

   assign sq_ctl[0]  = in_ctl_ff;
   assign sq_v[0]    = in_v_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_num[0]  = in_num_ff;

   // ---------------- square-root chain ----------------
   for (genvar i = 0; i < RB; i++) begin : g_sqrt
      rmq_sqrt_cell #(
         .VW2 (VW2),
         .RB  (RB)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (sq_ctl[i]),
         .v_i    (sq_v[i]),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .num_i  (sq_num[i]),
         .ctl_o  (sq_ctl[i+1]),
         .v_o    (sq_v[i+1]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1]),
         .num_o  (sq_num[i+1])
      );
   end

   // ---------------- divider setup ----------------
   logic [XW-1:0]   dtop;
   logic [XW-1:0]   dvd_c [3];
   rmq_lane_type    lane_c [3];
   logic [NW-1:0]   mag;

   always_comb begin
      dtop = XW'(sq_root[RB]) << (QBITS + 1);
      mag  = '0;
      for (int l = 0; l < 3; l++) begin
         mag            = sq_num[RB][l][NW-1] ? NW'(-sq_num[RB][l]) : NW'(sq_num[RB][l]);
         dvd_c[l]       = XW'(mag) << FRAC_BITS;
         lane_c[l].neg  = sq_num[RB][l][NW-1];
         lane_c[l].zero = (sq_num[RB][l] == '0);
         lane_c[l].sat  = (sq_num[RB][l] != '0) && (dvd_c[l] >= dtop);
      end
   end

   rmq_ctl_type       dv_ctl  [QBITS+1];
   logic [RB-1:0]     dv_root [QBITS+1];
   rmq_lane_type      dv_lane [QBITS+1][3];
   logic [XW-1:0]     dv_rem  [QBITS+1][3];
   logic [QBITS-1:0]  dv_q    [QBITS+1][3];

   rmq_ctl_type       su_ctl_ff;
   logic [RB-1:0]     su_root_ff;
   rmq_lane_type      su_lane_ff [3];
   logic [XW-1:0]     su_rem_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         su_ctl_ff.valid <= 1'b0;
      end else begin
         su_ctl_ff.valid <= sq_ctl[RB].valid;
      end
      su_ctl_ff.ident <= sq_ctl[RB].ident;
      su_ctl_ff.kind  <= sq_ctl[RB].kind;
      su_root_ff      <= sq_root[RB];
      su_lane_ff      <= lane_c;
      su_rem_ff       <= dvd_c;
   end

   assign dv_ctl[0]  = su_ctl_ff;
   assign dv_root[0] = su_root_ff;
   assign dv_lane[0] = su_lane_ff;
   assign dv_rem[0]  = su_rem_ff;
   assign dv_q[0]    = '{default: '0};

   // ---------------- divider chain ----------------
   for (genvar j = 0; j < QBITS; j++) begin : g_div
      rmq_div_cell #(
         .XW (XW),
         .RB (RB),
         .K  (QBITS - 1 - j)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (dv_ctl[j]),
         .root_i (dv_root[j]),
         .lane_i (dv_lane[j]),
         .rem_i  (dv_rem[j]),
         .q_i    (dv_q[j]),
         .ctl_o  (dv_ctl[j+1]),
         .root_o (dv_root[j+1]),
         .lane_o (dv_lane[j+1]),
         .rem_o  (dv_rem[j+1]),
         .q_o    (dv_q[j+1])
      );
   end

   // ---------------- saturation and output assembly ----------------
   logic signed [15:0] comp [3];
   logic signed [15:0] piv;
   logic signed [15:0] w_c, x_c, y_c, z_c;
   logic [RB-2:0]      half;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (dv_lane[QBITS][l].zero) begin
            comp[l] = '0;
         end else if (dv_lane[QBITS][l].sat) begin
            comp[l] = dv_lane[QBITS][l].neg ? 16'sh8000 : 16'sh7FFF;
         end else if (dv_lane[QBITS][l].neg) begin
            comp[l] = (dv_q[QBITS][l] > QBITS'(32768)) ? 16'sh8000
                                                       : 16'(-dv_q[QBITS][l]);
         end else begin
            comp[l] = (dv_q[QBITS][l] > QBITS'(32767)) ? 16'sh7FFF
                                                       : 16'(dv_q[QBITS][l]);
         end
      end
      half = dv_root[QBITS][RB-1:1];
      piv  = (RB'(half) > RB'(32767)) ? 16'sh7FFF : 16'(half);
      case (dv_ctl[QBITS].kind)
         KIND_TRACE: begin
            w_c = piv;     x_c = comp[0]; y_c = comp[1]; z_c = comp[2];
         end
         KIND_XX: begin
            w_c = comp[0]; x_c = piv;     y_c = comp[1]; z_c = comp[2];
         end
         KIND_YY: begin
            w_c = comp[0]; x_c = comp[1]; y_c = piv;     z_c = comp[2];
         end
         default: begin
            w_c = comp[0]; x_c = comp[1]; y_c = comp[2]; z_c = piv;
         end
      endcase
   end

   logic              rsp_valid_ff;
   logic signed [15:0] w_ff, x_ff, y_ff, z_ff;
   logic [2:0]        kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ctl[QBITS].valid;
      end
      if (dv_ctl[QBITS].ident) begin
         // identity shortcut
         w_ff    <= (FRAC_BITS > 14) ? 16'sh7FFF : 16'(ONE_W);
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
         kind_ff <= KIND_IDENT;
      end else begin
         w_ff    <= w_c;
         x_ff    <= x_c;
         y_ff    <= y_c;
         z_ff    <= z_c;
         kind_ff <= dv_ctl[QBITS].kind;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_w     = w_ff;
   assign rsp_quat_x     = x_ff;
   assign rsp_quat_y     = y_ff;
   assign rsp_quat_z     = z_ff;
   assign rsp_case_taken = kind_ff;

endmodule

`default_nettype wire
